@@ design/gwd_pkg.sv @@
package gwd_pkg;

   // Field widths of the request and response items
   localparam int OP_W    = 2;
   localparam int ROW_W   = 4;
   localparam int COL_W   = 4;
   localparam int CELL_W  = 8;
   localparam int SWEEP_W = 9;

   // Cell codes and limits
   localparam logic [CELL_W-1:0]  CELL_FREE    = 8'd0;
   localparam logic [CELL_W-1:0]  CELL_BLOCKED = 8'd255;
   localparam logic [CELL_W-1:0]  LABEL_MAX    = 8'd254;
   localparam logic [SWEEP_W-1:0] SWEEP_MAX    = 9'd511;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   // Neighbor visiting order of the wavefront
   typedef enum logic [1:0] {
      NBR_DOWN  = 2'd0,
      NBR_UP    = 2'd1,
      NBR_RIGHT = 2'd2,
      NBR_LEFT  = 2'd3
   } nbr_type;

   typedef enum logic [1:0] {
      RD_CUR = 2'd0,
      RD_NBR = 2'd1,
      RD_REQ = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_ZERO = 2'd0,
      WR_NBR  = 2'd1,
      WR_REQ  = 2'd2
   } wr_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic       req_load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       pos_clear;
      logic       pos_next;
      logic       nbr_clear;
      logic       nbr_next;
      logic       lab_load;
      logic       mark_changed;
      logic       run_init;
      logic       sweep_end;
      logic       out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_cell;
      logic req_inside;
      logic rd_labelled;
      logic rd_free;
      logic rd_blocked;
      logic nbr_inside;
      logic nbr_last;
      logic changed;
   } status_type;

endpackage

@@ design/gwd_ctrl.sv @@
module gwd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [gwd_pkg::OP_W-1:0]   req_opcode,
   input  logic                       rsp_stall,
   input  gwd_pkg::status_type        status,
   output gwd_pkg::cmd_type           cmd,
   output logic                       req_stall,
   output logic                       rsp_valid
);
   import gwd_pkg::*;

   typedef enum logic [11:0] {
      ST_INIT    = 12'b0000_0000_0001,
      ST_IDLE    = 12'b0000_0000_0010,
      ST_WRITE   = 12'b0000_0000_0100,
      ST_READ    = 12'b0000_0000_1000,
      ST_CLR_RD  = 12'b0000_0001_0000,
      ST_CLR_WR  = 12'b0000_0010_0000,
      ST_RUN_CTR = 12'b0000_0100_0000,
      ST_RUN_LAB = 12'b0000_1000_0000,
      ST_NBR_RD  = 12'b0001_0000_0000,
      ST_NBR_WR  = 12'b0010_0000_0000,
      ST_NEXT    = 12'b0100_0000_0000,
      ST_FINISH  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one item through the grid
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_ZERO;
            if (status.last_cell) begin
               cmd.pos_clear = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.pos_next = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               case (opcode_type'(req_opcode))
                  OP_WRITE: state_in = ST_WRITE;
                  OP_READ:  state_in = ST_READ;
                  OP_RUN: begin
                     cmd.run_init  = 1'b1;
                     cmd.pos_clear = 1'b1;
                     state_in      = ST_RUN_CTR;
                  end
                  default: begin
                     cmd.pos_clear = 1'b1;
                     state_in      = ST_CLR_RD;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            cmd.wr_en  = status.req_inside;
            cmd.wr_sel = WR_REQ;
            state_in   = ST_FINISH;
         end
         ST_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_REQ;
            state_in   = ST_FINISH;
         end
         ST_CLR_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CUR;
            state_in   = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            // drop every label, keep blocked cells
            cmd.wr_en  = !status.rd_blocked;
            cmd.wr_sel = WR_ZERO;
            if (status.last_cell) begin
               state_in = ST_FINISH;
            end else begin
               cmd.pos_next = 1'b1;
               state_in     = ST_CLR_RD;
            end
         end
         ST_RUN_CTR: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CUR;
            state_in   = ST_RUN_LAB;
         end
         ST_RUN_LAB: begin
            if (status.rd_labelled) begin
               cmd.lab_load  = 1'b1;
               cmd.nbr_clear = 1'b1;
               state_in      = ST_NBR_RD;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NBR_RD: begin
            if (status.nbr_inside) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NBR;
               state_in   = ST_NBR_WR;
            end else if (status.nbr_last) begin
               state_in = ST_NEXT;
            end else begin
               cmd.nbr_next = 1'b1;
            end
         end
         ST_NBR_WR: begin
            // label a free neighbor
            if (status.rd_free) begin
               cmd.wr_en        = 1'b1;
               cmd.wr_sel       = WR_NBR;
               cmd.mark_changed = 1'b1;
            end
            if (status.nbr_last) begin
               state_in = ST_NEXT;
            end else begin
               cmd.nbr_next = 1'b1;
               state_in     = ST_NBR_RD;
            end
         end
         ST_NEXT: begin
            if (status.last_cell) begin
               cmd.sweep_end = 1'b1;
               if (status.changed) begin
                  cmd.pos_clear = 1'b1;
                  state_in      = ST_RUN_CTR;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               cmd.pos_next = 1'b1;
               state_in     = ST_RUN_CTR;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Hold the result until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.out_load)
      else $error("held response overwritten");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (state_ff != ST_IDLE && state_ff != ST_FINISH))
      else $error("grid written while idle");

endmodule

@@ design/gwd_dpath.sv @@
module gwd_dpath #(
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gwd_pkg::cmd_type              cmd,
   input  logic [gwd_pkg::OP_W-1:0]      req_opcode,
   input  logic [gwd_pkg::ROW_W-1:0]     req_row,
   input  logic [gwd_pkg::COL_W-1:0]     req_col,
   input  logic [gwd_pkg::CELL_W-1:0]    req_cell_value,
   output gwd_pkg::status_type           status,
   output logic [gwd_pkg::CELL_W-1:0]    rsp_value_out,
   output logic [gwd_pkg::SWEEP_W-1:0]   rsp_sweep_count
);
   import gwd_pkg::*;

   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(GRID_ROWS);
   localparam int CW    = $clog2(GRID_COLS);

   logic [CELL_W-1:0]  grid_mem [CELLS];
   logic [CELL_W-1:0]  rd_data_ff;

   opcode_type         op_ff;
   logic [ROW_W-1:0]   row_req_ff;
   logic [COL_W-1:0]   col_req_ff;
   logic [CELL_W-1:0]  value_req_ff;

   logic [AW-1:0]      addr_ff, addr_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   nbr_type            nbr_ff, nbr_in;
   logic [CELL_W-1:0]  lab_ff;
   logic               changed_ff, changed_in;
   logic [SWEEP_W-1:0] sweeps_ff, sweeps_in;
   logic [CELL_W-1:0]  rsp_value_out_ff;
   logic [SWEEP_W-1:0] rsp_sweep_count_ff;

   logic               row_last, col_last;
   logic               req_inside;
   logic               nbr_inside;
   logic [AW-1:0]      req_addr, nbr_addr, rd_addr, wr_addr;
   logic [CELL_W-1:0]  wr_data, lab_next;

   // Decode request address
   assign req_inside = (int'(row_req_ff) < GRID_ROWS) && (int'(col_req_ff) < GRID_COLS);
   assign req_addr   = AW'(int'(row_req_ff) * GRID_COLS + int'(col_req_ff));

   assign row_last = (row_ff == RW'(GRID_ROWS - 1));
   assign col_last = (col_ff == CW'(GRID_COLS - 1));

   // Pick the current neighbor and test the grid edge
   always_comb begin
      case (nbr_ff)
         NBR_DOWN: begin
            nbr_addr   = addr_ff + AW'(GRID_COLS);
            nbr_inside = !row_last;
         end
         NBR_UP: begin
            nbr_addr   = addr_ff - AW'(GRID_COLS);
            nbr_inside = (row_ff != '0);
         end
         NBR_RIGHT: begin
            nbr_addr   = addr_ff + AW'(1);
            nbr_inside = !col_last;
         end
         default: begin
            nbr_addr   = addr_ff - AW'(1);
            nbr_inside = (col_ff != '0);
         end
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_NBR:  rd_addr = nbr_addr;
         RD_REQ:  rd_addr = req_addr;
         default: rd_addr = addr_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_NBR: begin
            wr_addr = nbr_addr;
            wr_data = lab_ff;
         end
         WR_REQ: begin
            wr_addr = req_addr;
            wr_data = value_req_ff;
         end
         default: begin
            wr_addr = addr_ff;
            wr_data = CELL_FREE;
         end
      endcase
   end

   // Grid store, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   // Spread label, saturate below blocked
   assign lab_next = (rd_data_ff >= LABEL_MAX) ? LABEL_MAX : rd_data_ff + CELL_W'(1);

   // Advance the scan position and the neighbor, and track the changed flag and sweep count
   always_comb begin
      addr_in = addr_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (cmd.pos_clear) begin
         addr_in = '0;
         row_in  = '0;
         col_in  = '0;
      end else if (cmd.pos_next) begin
         addr_in = addr_ff + AW'(1);
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      nbr_in = nbr_ff;
      if (cmd.nbr_clear) begin
         nbr_in = NBR_DOWN;
      end else if (cmd.nbr_next) begin
         nbr_in = nbr_type'(nbr_ff + 2'd1);
      end

      changed_in = changed_ff;
      sweeps_in  = sweeps_ff;
      if (cmd.run_init) begin
         changed_in = 1'b0;
         sweeps_in  = '0;
      end else if (cmd.sweep_end) begin
         changed_in = 1'b0;
         if (sweeps_ff != SWEEP_MAX) begin
            sweeps_in = sweeps_ff + SWEEP_W'(1);
         end
      end else if (cmd.mark_changed) begin
         changed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         nbr_ff     <= NBR_DOWN;
         changed_ff <= 1'b0;
         sweeps_ff  <= '0;
      end else begin
         addr_ff    <= addr_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         nbr_ff     <= nbr_in;
         changed_ff <= changed_in;
         sweeps_ff  <= sweeps_in;
      end
   end

   // Capture the request and the center label
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff        <= opcode_type'(req_opcode);
         row_req_ff   <= req_row;
         col_req_ff   <= req_col;
         value_req_ff <= req_cell_value;
      end
      if (cmd.lab_load) begin
         lab_ff <= lab_next;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (op_ff)
            OP_WRITE: rsp_value_out_ff <= value_req_ff;
            OP_READ:  rsp_value_out_ff <= req_inside ? rd_data_ff : CELL_FREE;
            default:  rsp_value_out_ff <= CELL_FREE;
         endcase
         rsp_sweep_count_ff <= (op_ff == OP_RUN) ? sweeps_ff : '0;
      end
   end

   assign rsp_value_out   = rsp_value_out_ff;
   assign rsp_sweep_count = rsp_sweep_count_ff;

   assign status.last_cell   = row_last && col_last;
   assign status.req_inside  = req_inside;
   assign status.rd_free     = (rd_data_ff == CELL_FREE);
   assign status.rd_blocked  = (rd_data_ff == CELL_BLOCKED);
   assign status.rd_labelled = !status.rd_free && !status.rd_blocked;
   assign status.nbr_inside  = nbr_inside;
   assign status.nbr_last    = (nbr_ff == NBR_LEFT);
   assign status.changed     = changed_ff;

   a_lab_from_label: assert property (@(posedge clock) disable iff (reset)
      cmd.lab_load |-> (rd_data_ff != CELL_FREE && rd_data_ff != CELL_BLOCKED))
      else $error("label taken from a free or blocked cell");

   a_nbr_write_inside: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.wr_sel == WR_NBR) |-> (nbr_inside && lab_ff != CELL_BLOCKED))
      else $error("neighbor write off the grid or with blocked code");

   a_scan_in_grid: assert property (@(posedge clock) disable iff (reset)
      (int'(addr_ff) < CELLS) && (int'(row_ff) < GRID_ROWS))
      else $error("scan position left the grid");

endmodule

@@ design/grid_wavefront_distance.sv @@
// Grassfire distance grid. Holds GRID_ROWS x GRID_COLS cells of 8 bits (0 free,
// 255 blocked, other values distance labels, 1 = seed). Each request item gives
// one response item. A run repeats row-major sweeps until one sweep changes
// nothing; each sweep reads every cell and, for a labelled cell, reads each
// in-grid neighbor and labels it if free. The grid sits in a single-port memory
// that the sweep sequencer visits one access per cycle. After reset the block
// zeroes every cell of the grid with req_stall high. A finished response waits
// in an output register while the next item is taken.
module grid_wavefront_distance #(
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gwd_pkg::OP_W-1:0]      req_opcode,
   input  logic [gwd_pkg::ROW_W-1:0]     req_row,
   input  logic [gwd_pkg::COL_W-1:0]     req_col,
   input  logic [gwd_pkg::CELL_W-1:0]    req_cell_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gwd_pkg::CELL_W-1:0]    rsp_value_out,
   output logic [gwd_pkg::SWEEP_W-1:0]   rsp_sweep_count
);
   import gwd_pkg::*;

   cmd_type    cmd;
   status_type status;

   gwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid)
   );

   gwd_dpath #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_cell_value  (req_cell_value),
      .status          (status),
      .rsp_value_out   (rsp_value_out),
      .rsp_sweep_count (rsp_sweep_count)
   );

endmodule

@@ bench/wavefront_monitor.sv @@
`timescale 1ns / 100ps

module wavefront_monitor #(
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [gwd_pkg::OP_W-1:0]    req_opcode,
   input  logic [gwd_pkg::ROW_W-1:0]   req_row,
   input  logic [gwd_pkg::COL_W-1:0]   req_col,
   input  logic [gwd_pkg::CELL_W-1:0]  req_cell_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [gwd_pkg::CELL_W-1:0]  rsp_value_out,
   input  logic [gwd_pkg::SWEEP_W-1:0] rsp_sweep_count,
   output int                          errors,
   output int                          outstanding,
   output int                          responses,
   output int                          runs,
   output int                          peak_sweeps,
   output int                          saturated_reads
);
   import gwd_pkg::*;

   typedef struct packed {
      logic [CELL_W-1:0]  value;
      logic [SWEEP_W-1:0] sweeps;
   } rsp_fields_type;

   // Shadow copy of the grid and the responses still owed by the block
   logic [CELL_W-1:0] grid_mirror [GRID_ROWS][GRID_COLS];
   rsp_fields_type    due_rsp [$];

   // Repeat in-place row-major sweeps until one sweep labels nothing
   function automatic logic [SWEEP_W-1:0] spread_labels();
      logic [SWEEP_W-1:0] sweeps;
      logic [CELL_W-1:0]  here;
      logic [CELL_W-1:0]  lab;
      bit                 changed;
      nbr_type            dir;
      int                 nr;
      int                 nc;
      sweeps  = '0;
      changed = 1'b1;
      while (changed) begin
         changed = 1'b0;
         for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
               here = grid_mirror[r][c];
               if (here != CELL_FREE && here != CELL_BLOCKED) begin
                  lab = (here >= LABEL_MAX) ? LABEL_MAX : here + 8'd1;
                  // visit down, up, right, left
                  for (int k = 0; k < 4; k++) begin
                     dir = nbr_type'(k);
                     nr  = r;
                     nc  = c;
                     case (dir)
                        NBR_DOWN:  nr = r + 1;
                        NBR_UP:    nr = r - 1;
                        NBR_RIGHT: nc = c + 1;
                        default:   nc = c - 1;
                     endcase
                     if (nr >= 0 && nr < GRID_ROWS && nc >= 0 && nc < GRID_COLS) begin
                        if (grid_mirror[nr][nc] == CELL_FREE) begin
                           grid_mirror[nr][nc] = lab;
                           changed = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         if (sweeps != SWEEP_MAX)
            sweeps++;
      end
      return sweeps;
   endfunction

   always @(posedge clock) begin : watch
      rsp_fields_type want;
      rsp_fields_type got;
      bit             in_grid;
      if (reset) begin
         foreach (grid_mirror[r, c])
            grid_mirror[r][c] = CELL_FREE;
         due_rsp.delete();
         errors          <= 0;
         outstanding     <= 0;
         responses       <= 0;
         runs            <= 0;
         peak_sweeps     <= 0;
         saturated_reads <= 0;
      end else begin
         // Check a delivered item against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.value  = rsp_value_out;
            got.sweeps = rsp_sweep_count;
            responses <= responses + 1;
            if (due_rsp.size() == 0) begin
               errors <= errors + 1;
               $display("%0t: unexpected response, got value %0d sweeps %0d",
                        $time, got.value, got.sweeps);
            end else begin
               want = due_rsp.pop_front();
               if (got !== want) begin
                  errors <= errors + 1;
                  $display("%0t: response mismatch, expected value %0d sweeps %0d, got value %0d sweeps %0d",
                           $time, want.value, want.sweeps, got.value, got.sweeps);
               end
            end
         end

         // Predict the response of an accepted item
         if (req_valid && !req_stall) begin
            want    = '0;
            in_grid = (req_row < GRID_ROWS) && (req_col < GRID_COLS);
            case (opcode_type'(req_opcode))
               OP_WRITE: begin
                  if (in_grid)
                     grid_mirror[req_row][req_col] = req_cell_value;
                  want.value = req_cell_value;
               end
               OP_RUN: begin
                  want.sweeps = spread_labels();
                  runs <= runs + 1;
                  if (want.sweeps > peak_sweeps)
                     peak_sweeps <= want.sweeps;
               end
               OP_READ: begin
                  if (in_grid)
                     want.value = grid_mirror[req_row][req_col];
                  if (want.value == LABEL_MAX)
                     saturated_reads <= saturated_reads + 1;
               end
               default: begin
                  foreach (grid_mirror[r, c])
                     if (grid_mirror[r][c] != CELL_BLOCKED)
                        grid_mirror[r][c] = CELL_FREE;
               end
            endcase
            due_rsp.push_back(want);
         end
         outstanding <= due_rsp.size();
      end
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import gwd_pkg::*;

   localparam int GRID_ROWS    = 16;
   localparam int GRID_COLS    = 16;
   localparam int ITEM_TARGET  = 900;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 10_000_000;
   localparam logic [CELL_W-1:0] SEED_LABEL = 8'd1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [OP_W-1:0]    req_opcode = OP_WRITE;
   logic [ROW_W-1:0]   req_row = '0;
   logic [COL_W-1:0]   req_col = '0;
   logic [CELL_W-1:0]  req_cell_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CELL_W-1:0]  rsp_value_out;
   logic [SWEEP_W-1:0] rsp_sweep_count;

   int errors;
   int outstanding;
   int responses;
   int runs;
   int peak_sweeps;
   int saturated_reads;

   int items_sent   = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int cycles       = 0;
   bit hold_now     = 1'b0;
   bit hold_done    = 1'b0;

   always #2 clock = ~clock;

   grid_wavefront_distance #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_cell_value  (req_cell_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value_out   (rsp_value_out),
      .rsp_sweep_count (rsp_sweep_count)
   );

   wavefront_monitor #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_cell_value  (req_cell_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value_out   (rsp_value_out),
      .rsp_sweep_count (rsp_sweep_count),
      .errors          (errors),
      .outstanding     (outstanding),
      .responses       (responses),
      .runs            (runs),
      .peak_sweeps     (peak_sweeps),
      .saturated_reads (saturated_reads)
   );

   // A gap with pct percent chance: mostly short, now and then long
   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(12, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 10;
         2:       return 30;
         default: return 60;
      endcase
   endfunction

   // Offer one item and hold it until the block takes it
   task automatic send_item(opcode_type op, int row, int col, int value);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_row        <= row[ROW_W-1:0];
      req_col        <= col[COL_W-1:0];
      req_cell_value <= value[CELL_W-1:0];
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Receiver: random stalls, plus one long hold-off to back the block up
   initial begin : receiver
      int gap;
      forever begin
         @(posedge clock);
         if (hold_now && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap(rsp_idle_pct);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap - 1) @(posedge clock);
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Abort on a hung block
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timed out after %0d cycles, %0d responses outstanding",
                  $time, cycles, outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int op;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty grid, corner seed, blocked corner, clear, saturation
      send_item(OP_RUN, 0, 0, 0);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_WRITE, 0, 0, SEED_LABEL);
      send_item(OP_WRITE, 15, 15, CELL_BLOCKED);
      send_item(OP_WRITE, 0, 15, CELL_BLOCKED);
      send_item(OP_WRITE, 1, 14, CELL_BLOCKED);
      send_item(OP_WRITE, 15, 0, 8'h55);
      send_item(OP_RUN, 15, 15, 255);
      send_item(OP_READ, 15, 14, 0);
      send_item(OP_READ, 15, 15, 0);
      send_item(OP_READ, 0, 14, 0);
      send_item(OP_READ, 14, 15, 0);
      send_item(OP_CLEAR, 7, 9, 8'hAA);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_READ, 15, 15, 0);
      send_item(OP_WRITE, 8, 8, 253);
      send_item(OP_RUN, 0, 0, 0);
      send_item(OP_READ, 8, 9, 0);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_READ, 8, 8, 0);
      send_item(OP_WRITE, 3, 3, LABEL_MAX);
      send_item(OP_WRITE, 3, 3, CELL_FREE);
      send_item(OP_CLEAR, 15, 15, 255);
      send_item(OP_RUN, 15, 0, 0);
      send_item(OP_READ, 15, 15, 0);

      // Random: well-formed map/run/probe episodes mixed with noise
      req_idle_pct = 0;
      hold_now     = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1))
               send_item(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 255));
            repeat ($urandom_range(0, 40))
               send_item(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                         CELL_BLOCKED);
            repeat ($urandom_range(0, 4))
               send_item(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                         CELL_FREE);
            repeat ($urandom_range(1, 3))
               send_item(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(2, 254)
                                                     : SEED_LABEL);
            send_item(OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 255));
            repeat ($urandom_range(8, 24))
               send_item(OP_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 255));
         end else begin
            repeat ($urandom_range(5, 20)) begin
               op = $urandom_range(0, 3);
               // keep runs rare in noise, they cost whole sweeps
               if (op == OP_RUN && $urandom_range(0, 3) != 0)
                  op = OP_READ;
               send_item(opcode_type'(op), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 255));
            end
         end
         req_idle_pct = pick_pct();
         rsp_idle_pct = pick_pct();
      end
      req_valid <= 1'b0;

      // Drain, then keep watching for anything unasked-for
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items and checked %0d responses, with %0d mismatches.",
               items_sent, responses, errors);
      $display("Wavefront runs: %0d, deepest %0d sweeps; saturated labels read back: %0d.",
               runs, peak_sweeps, saturated_reads);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
